/* rtl/ppm_pkg.sv */
package ppm_pkg;

	typedef logic [1:0] cmd_code_t;

	localparam cmd_code_t CMD_POWER  = 2'd0;
	localparam cmd_code_t CMD_SHARED = 2'd1;
	localparam cmd_code_t CMD_POLL   = 2'd2;
	localparam cmd_code_t CMD_CLEAR  = 2'd3;

	typedef logic [2:0] reg_index_t;

	localparam reg_index_t REG_TIMEOUT      = 3'd0;
	localparam reg_index_t REG_POWER_GAIN   = 3'd1;
	localparam reg_index_t REG_VOLTAGE_GAIN = 3'd2;
	localparam reg_index_t REG_CURRENT_GAIN = 3'd3;
	localparam reg_index_t REG_ENERGY_GAIN  = 3'd4;

	localparam logic [31:0] RST_TIMEOUT      = 32'd3000000;
	localparam logic [31:0] RST_POWER_GAIN   = 32'd1361921538;
	localparam logic [31:0] RST_VOLTAGE_GAIN = 32'd119730000;
	localparam logic [31:0] RST_CURRENT_GAIN = 32'd11497579;
	localparam logic [15:0] RST_ENERGY_GAIN  = 16'd24849;

	typedef logic [1:0] qsel_t;

	localparam qsel_t QSEL_POWER   = 2'd0;
	localparam qsel_t QSEL_VOLTAGE = 2'd1;
	localparam qsel_t QSEL_CURRENT = 2'd2;

	typedef struct packed {
		cmd_code_t   cmd;
		logic [31:0] time_us;
		logic        select_level;
	} in_item_t;

	typedef struct packed {
		logic [31:0] energy_pulses;
		logic [31:0] energy_mwh;
		logic [31:0] power_period_us;
		logic [31:0] voltage_period_us;
		logic [31:0] current_period_us;
		logic [31:0] power_mw;
		logic [31:0] voltage_mv;
		logic [31:0] current_ma;
	} out_item_t;

	typedef struct packed {
		logic  capture;
		logic  update;
		logic  div_start;
		qsel_t div_sel;
		logic  div_store;
		logic  out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic div_done;
	} dp_status_t;

endpackage

/* rtl/pulse_period_power_meter.sv */
// The block takes metering events on the input channel (in_valid, in_ready, in_data): a
// power pulse edge, a voltage/current pulse edge with the select level, a poll tick or a
// clear of the energy count, each with a microsecond timestamp. For every request it returns
// one result on the output channel (out_valid, out_ready, out_data) with the pulse count,
// the energy, the three periods and the power, voltage and current values.
// One request is processed at a time: a new request is accepted only after the result of the
// last one has been loaded into the output register. The three quotients are computed one
// after another by a single divider that retires two quotient bits per cycle.
// The result sits in an output register, so a stalled receiver does not stop the next
// request from being accepted and processed; that request waits in its final state until
// the output register is free.
// The user writes the gains and the silence timeout through cfg_we, cfg_index and cfg_data only
// while no request is in flight, not enforced by the block; writes to unused indexes are ignored.
// Reset clears the counters, edge times, periods and select history, and loads the default
// gains and timeout. The block accepts a request in the first cycle after reset.
module pulse_period_power_meter #(
	parameter int TIME_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ppm_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ppm_pkg::out_item_t  out_data,
	input  logic                cfg_we,
	input  ppm_pkg::reg_index_t cfg_index,
	input  logic [31:0]         cfg_data
);

	ppm_pkg::ctrl_cmd_t  cmd;
	ppm_pkg::dp_status_t status;

	ppm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	ppm_dp #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.out_data  (out_data)
	);

endmodule

/* rtl/ppm_div.sv */
module ppm_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);

	logic [31:0] rem_q;
	logic [31:0] quot_q;
	logic [31:0] den_q;
	logic [3:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [31:0] rem_a;
	logic [31:0] rem_b;
	logic        bit_a;
	logic        bit_b;

	function automatic logic [32:0] div_step(input logic [31:0] rem, input logic nxt,
			input logic [31:0] den);
		logic [32:0] shifted;
		logic [32:0] diff;
		shifted = {rem, nxt};
		diff    = shifted - {1'b0, den};
		if (shifted >= {1'b0, den}) begin
			div_step = {1'b1, diff[31:0]};
		end else begin
			div_step = {1'b0, shifted[31:0]};
		end
	endfunction

	// Two restoring steps per cycle.
	always_comb begin
		{bit_a, rem_a} = div_step(rem_q, quot_q[31], den_q);
		{bit_b, rem_b} = div_step(rem_a, quot_q[30], den_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == 4'd15);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quot_q <= dividend;
			den_q  <= divisor;
		end else if (busy_q) begin
			rem_q  <= rem_b;
			quot_q <= {quot_q[29:0], bit_a, bit_b};
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

/* rtl/ppm_dp.sv */
module ppm_dp #(
	parameter int TIME_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ppm_pkg::in_item_t   in_data,
	input  logic                cfg_we,
	input  ppm_pkg::reg_index_t cfg_index,
	input  logic [31:0]         cfg_data,
	input  ppm_pkg::ctrl_cmd_t  cmd,
	output ppm_pkg::dp_status_t status,
	output ppm_pkg::out_item_t  out_data
);

	localparam int CW = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

	logic [31:0] timeout_q;
	logic [31:0] power_gain_q;
	logic [31:0] voltage_gain_q;
	logic [31:0] current_gain_q;
	logic [15:0] energy_gain_q;

	ppm_pkg::in_item_t item_q;

	logic [31:0]           pulse_count_q;
	logic [TIME_WIDTH-1:0] last_power_q;
	logic [TIME_WIDTH-1:0] last_shared_q;
	logic [TIME_WIDTH-1:0] last_current_q;
	logic [31:0]           power_period_q;
	logic [31:0]           voltage_period_q;
	logic [31:0]           current_period_q;
	logic                  prev_sel_q;
	logic                  prev_sel_valid_q;

	logic [31:0] energy_q;
	logic [31:0] power_mw_q;
	logic [31:0] voltage_mv_q;
	logic [31:0] current_ma_q;

	logic [TIME_WIDTH-1:0] t_now;
	logic [TIME_WIDTH-1:0] diff_power;
	logic [TIME_WIDTH-1:0] diff_shared;
	logic [TIME_WIDTH-1:0] diff_current;
	logic                  stale_power;
	logic                  stale_current;
	logic [47:0]           energy_prod;
	logic [31:0]           div_gain;
	logic [31:0]           div_period;
	logic                  div_done;
	logic [31:0]           div_quot;
	logic [31:0]           quot_final;

	always_comb begin
		t_now         = TIME_WIDTH'(CW'(item_q.time_us));
		diff_power    = t_now - last_power_q;
		diff_shared   = t_now - last_shared_q;
		diff_current  = t_now - last_current_q;
		stale_power   = CW'(diff_power) > CW'(timeout_q);
		stale_current = CW'(diff_current) > CW'(timeout_q);
		energy_prod   = {16'd0, pulse_count_q} * {32'd0, energy_gain_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q      <= ppm_pkg::RST_TIMEOUT;
			power_gain_q   <= ppm_pkg::RST_POWER_GAIN;
			voltage_gain_q <= ppm_pkg::RST_VOLTAGE_GAIN;
			current_gain_q <= ppm_pkg::RST_CURRENT_GAIN;
			energy_gain_q  <= ppm_pkg::RST_ENERGY_GAIN;
		end else if (cfg_we) begin
			case (cfg_index)
				ppm_pkg::REG_TIMEOUT:      timeout_q      <= cfg_data;
				ppm_pkg::REG_POWER_GAIN:   power_gain_q   <= cfg_data;
				ppm_pkg::REG_VOLTAGE_GAIN: voltage_gain_q <= cfg_data;
				ppm_pkg::REG_CURRENT_GAIN: current_gain_q <= cfg_data;
				ppm_pkg::REG_ENERGY_GAIN:  energy_gain_q  <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_count_q    <= '0;
			last_power_q     <= '0;
			last_shared_q    <= '0;
			last_current_q   <= '0;
			power_period_q   <= '0;
			voltage_period_q <= '0;
			current_period_q <= '0;
			prev_sel_q       <= 1'b0;
			prev_sel_valid_q <= 1'b0;
		end else if (cmd.update) begin
			case (item_q.cmd)
				ppm_pkg::CMD_POWER: begin
					power_period_q <= 32'(diff_power);
					last_power_q   <= t_now;
					pulse_count_q  <= pulse_count_q + 32'd1;
				end
				ppm_pkg::CMD_SHARED: begin
					last_shared_q <= t_now;
					if (prev_sel_valid_q && (prev_sel_q == item_q.select_level)) begin
						if (item_q.select_level) begin
							voltage_period_q <= 32'(diff_shared);
						end else begin
							current_period_q <= 32'(diff_shared);
							last_current_q   <= t_now;
						end
					end
					prev_sel_q       <= item_q.select_level;
					prev_sel_valid_q <= 1'b1;
				end
				ppm_pkg::CMD_POLL: begin
					if (stale_power) begin
						power_period_q <= '0;
					end
					if (stale_current && !item_q.select_level) begin
						current_period_q <= '0;
					end
				end
				ppm_pkg::CMD_CLEAR: begin
					pulse_count_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (cmd.div_sel)
			ppm_pkg::QSEL_POWER: begin
				div_gain   = power_gain_q;
				div_period = power_period_q;
			end
			ppm_pkg::QSEL_VOLTAGE: begin
				div_gain   = voltage_gain_q;
				div_period = voltage_period_q;
			end
			default: begin
				div_gain   = current_gain_q;
				div_period = current_period_q;
			end
		endcase
		quot_final = (div_period == 32'd0) ? 32'd0 : div_quot;
	end

	ppm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_gain),
		.divisor  (div_period),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_data;
		end
		if (cmd.div_start) begin
			energy_q <= energy_prod[47:16];
		end
		if (cmd.div_store) begin
			case (cmd.div_sel)
				ppm_pkg::QSEL_POWER:   power_mw_q   <= quot_final;
				ppm_pkg::QSEL_VOLTAGE: voltage_mv_q <= quot_final;
				default:               current_ma_q <= quot_final;
			endcase
		end
		if (cmd.out_load) begin
			out_data.energy_pulses     <= pulse_count_q;
			out_data.energy_mwh        <= energy_q;
			out_data.power_period_us   <= power_period_q;
			out_data.voltage_period_us <= voltage_period_q;
			out_data.current_period_us <= current_period_q;
			out_data.power_mw          <= power_mw_q;
			out_data.voltage_mv        <= voltage_mv_q;
			out_data.current_ma        <= current_ma_q;
		end
	end

	assign status.div_done = div_done;

endmodule

/* rtl/ppm_ctrl.sv */
module ppm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  ppm_pkg::dp_status_t status,
	output ppm_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_UPDATE,
		S_START,
		S_WAIT,
		S_OUT
	} state_t;

	state_t         state_q;
	ppm_pkg::qsel_t sel_q;
	logic           out_valid_q;
	logic           out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		cmd           = '0;
		cmd.div_sel   = sel_q;
		cmd.capture   = (state_q == S_IDLE) && in_valid;
		cmd.update    = (state_q == S_UPDATE);
		cmd.div_start = (state_q == S_START);
		cmd.div_store = (state_q == S_WAIT) && status.div_done;
		cmd.out_load  = (state_q == S_OUT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sel_q       <= ppm_pkg::QSEL_POWER;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_UPDATE;
					end
				end
				S_UPDATE: begin
					sel_q   <= ppm_pkg::QSEL_POWER;
					state_q <= S_START;
				end
				S_START: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (status.div_done) begin
						if (sel_q == ppm_pkg::QSEL_CURRENT) begin
							state_q <= S_OUT;
						end else begin
							sel_q   <= sel_q + 2'd1;
							state_q <= S_START;
						end
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule
